[rtl/kppi_pkg.sv]
// Shared types and constants for the k-mer prefix presence index.
// Used by every module of the block but kppi_ram; depends on nothing else.
package kppi_pkg;

  localparam int KMER_LEN = 8;
  localparam int CODE_W   = 2 * KMER_LEN;
  localparam int LEN_W    = $clog2(KMER_LEN + 1);
  localparam int BASE_W   = 3;
  localparam int KMER_W   = 16;
  localparam int PLEN_W   = 4;

  localparam logic [BASE_W-1:0] BASE_LAST_VALID = BASE_W'(3);

  typedef enum logic {
    OP_FEED  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // An item on its way along the row of cells.
  typedef struct packed {
    logic             valid;
    op_t              op;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  run;
    logic [LEN_W-1:0]  best;
  } token_t;

  // Clearing sweep that runs through every bank after reset.
  typedef struct packed {
    logic              active;
    logic [CODE_W-1:0] addr;
  } clear_t;

  // Request from a cell to its bitmap bank.
  typedef struct packed {
    logic              en;
    logic              we;
    logic [CODE_W-1:0] addr;
    logic              wdata;
  } bank_req_t;

endpackage

[rtl/kppi_ram.sv]
// Single-port bit memory holding one presence bitmap bank.
// Generic; registered read, read returns the old contents on a write.
module kppi_ram #(
  parameter int ADDR_W = 2
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic              wdata,
  output logic              rdata
);

  logic mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/kppi_cell.sv]
// One cell of the row: owns the bitmap bank of one k-mer length.
// Depends on kppi_pkg; its bank is a kppi_ram instance placed by the top level.
module kppi_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic [kppi_pkg::LEN_W-1:0] level,
  input  kppi_pkg::clear_t       clr,
  input  kppi_pkg::token_t       tok_in,
  input  logic                   hit_in,
  output kppi_pkg::token_t       tok_out,
  output kppi_pkg::bank_req_t    req
);
  import kppi_pkg::*;

  logic [CODE_W-1:0] feed_mask;
  logic [LEN_W-1:0]  shift_len;
  logic [CODE_W-1:0] look_addr;
  logic              feed_write;
  logic [LEN_W-1:0]  best_fold;

  // A feed marks the j-mer in the low 2j bits of the window; a query looks
  // up its leading j bases.
  always_comb begin
    feed_mask = ~({CODE_W{1'b1}} << {level, 1'b0});
    shift_len = LEN_W'(KMER_LEN) - level;
    if (tok_in.op == OP_FEED) begin
      look_addr = tok_in.code & feed_mask;
    end else begin
      look_addr = tok_in.code >> {shift_len, 1'b0};
    end
    feed_write = tok_in.valid && (tok_in.op == OP_FEED) && (tok_in.run >= level);
  end

  // The previous cell's lookup result arrives alongside the item.
  always_comb begin
    if (tok_in.valid && (tok_in.op == OP_QUERY) && hit_in) begin
      best_fold = level - LEN_W'(1);
    end else begin
      best_fold = tok_in.best;
    end
  end

  always_comb begin
    req.en    = clr.active || adv;
    req.we    = clr.active || (adv && feed_write);
    req.addr  = clr.active ? clr.addr : look_addr;
    req.wdata = !clr.active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (adv) begin
      tok_out.valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_out.op   <= tok_in.op;
      tok_out.code <= tok_in.code;
      tok_out.run  <= tok_in.run;
      tok_out.best <= best_fold;
    end
  end

endmodule

[rtl/kmer_prefix_presence_index_core.sv]
// Top level of the k-mer prefix presence index: head stage, row of cells with
// one bitmap bank per length, output register. Depends on kppi_pkg, kppi_cell, kppi_ram.
//
// The block takes one item per cycle. A feed item shifts a base into the window
// of the last KMER_LEN bases and marks every j-mer it completes; a query item
// returns the longest leading length of its k-mer that has been seen. Each item
// passes a head register and then one cell per length, each cell owning that
// length's bitmap in a single-port bank; a query result then passes the output
// register, and a feed gives no result. The row moves as one: while a result
// waits at the output and out_ready is low, nothing moves. After reset the
// block runs a clearing pass over all 4^KMER_LEN addresses (65536 for KMER_LEN
// of 8), sweeping one address of every bank per cycle, and holds in_ready low
// until it is done. Items leave in the order they came, so a query always sees
// every feed accepted before it.
module kmer_prefix_presence_index_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            operation,
  input  logic [kppi_pkg::BASE_W-1:0]     base,
  input  logic [kppi_pkg::KMER_W-1:0]     kmer_code,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kppi_pkg::PLEN_W-1:0]     prefix_length
);
  import kppi_pkg::*;

  // Whole row advances unless a result is held at the output.
  logic adv;
  logic accept;

  // Clearing pass state.
  logic              clearing;
  logic [CODE_W-1:0] clr_cnt;
  clear_t            clr;

  // Window of recent bases and the run of valid bases.
  logic [CODE_W-1:0] window;
  logic [CODE_W-1:0] window_next;
  logic [LEN_W-1:0]  run;
  logic [LEN_W-1:0]  run_next;

  // tok[0] is the head register; tok[j] leaves cell j.
  token_t tok [KMER_LEN+1];
  logic   hit [KMER_LEN+1];

  logic [LEN_W-1:0] best_last;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !clearing;
  assign accept   = in_valid && in_ready;

  assign clr.active = clearing;
  assign clr.addr   = clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + CODE_W'(1);
      if (clr_cnt == {CODE_W{1'b1}}) begin
        clearing <= 1'b0;
      end
    end
  end

  // A base outside A, C, G, T breaks the run and leaves the window alone.
  always_comb begin
    window_next = window;
    run_next    = run;
    if (operation == OP_FEED) begin
      if (base > BASE_LAST_VALID) begin
        run_next = '0;
      end else begin
        window_next = {window[CODE_W-3:0], base[1:0]};
        if (run != LEN_W'(KMER_LEN)) begin
          run_next = run + LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      run    <= '0;
    end else if (accept) begin
      window <= window_next;
      run    <= run_next;
    end
  end

  // Head register: a feed carries the updated window and run, a query its
  // k-mer widened or trimmed to the window width.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else if (adv) begin
      tok[0].valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok[0].op   <= op_t'(operation);
      tok[0].best <= '0;
      if (operation == OP_FEED) begin
        tok[0].code <= window_next;
        tok[0].run  <= run_next;
      end else begin
        tok[0].code <= CODE_W'(kmer_code);
        tok[0].run  <= '0;
      end
    end
  end

  assign hit[0] = 1'b0;

  for (genvar j = 1; j <= KMER_LEN; j++) begin : g_cell
    bank_req_t req;

    kppi_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .level   (LEN_W'(j)),
      .clr     (clr),
      .tok_in  (tok[j-1]),
      .hit_in  (hit[j-1]),
      .tok_out (tok[j]),
      .req     (req)
    );

    kppi_ram #(
      .ADDR_W (2 * j)
    ) u_bank (
      .clk   (clk),
      .en    (req.en),
      .we    (req.we),
      .addr  (req.addr[2*j-1:0]),
      .wdata (req.wdata),
      .rdata (hit[j])
    );
  end

  // The last cell's lookup folds in at the output register.
  always_comb begin
    if (hit[KMER_LEN] && (tok[KMER_LEN].op == OP_QUERY)) begin
      best_last = LEN_W'(KMER_LEN);
    end else begin
      best_last = tok[KMER_LEN].best;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= tok[KMER_LEN].valid && (tok[KMER_LEN].op == OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prefix_length <= PLEN_W'(best_last);
    end
  end

endmodule

[rtl/kppi_checker.sv]
// Port-level checks for the k-mer prefix presence index, bound to the top level.
// Depends on kppi_pkg and kmer_prefix_presence_index_core.
module kppi_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [kppi_pkg::PLEN_W-1:0] prefix_length
);
  import kppi_pkg::*;

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A held result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(prefix_length))
    else $error("result changed while stalled");

  // No length beyond the k-mer can be reported.
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> prefix_length <= PLEN_W'(KMER_LEN))
    else $error("prefix length out of range");

  // The clearing pass keeps the input closed straight after reset.
  a_clear_closed: assert property (@(posedge clk)
    $past(rst) |-> !in_ready)
    else $error("item taken during clearing pass");

  // Nothing can come in while a result waits and the row is frozen.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input open while output stalled");

endmodule

bind kmer_prefix_presence_index_core kppi_checker u_kppi_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .prefix_length (prefix_length)
);
